FILE: sv/lps_pkg.sv
// Package for the linear prime sieve: sizes, derived widths, limits and the
// sequencer state type. Used by the interfaces and the top level of the block.
// Depends on nothing.
package lps_pkg;

  // Storage sizes.
  localparam int unsigned MAX_VALUE  = 65536;
  localparam int unsigned MAX_PRIMES = 8192;

  // Fixed field widths.
  localparam int unsigned CAND_W  = 16;
  localparam int unsigned COUNT_W = 13;

  // Derived widths and limits.
  localparam int unsigned VAL_W     = $clog2(MAX_VALUE);
  localparam int unsigned PRIME_AW  = $clog2(MAX_PRIMES);
  localparam int unsigned VALUE_TOP = MAX_VALUE - 1;
  localparam int unsigned COUNT_TOP = (1 << COUNT_W) - 1;
  localparam int unsigned LIST_CAP  =
    (MAX_PRIMES - 1 < COUNT_TOP) ? MAX_PRIMES - 1 : COUNT_TOP;

  // Remainder unit: bits retired per cycle and cycles per remainder.
  localparam int unsigned DIV_BPC    = 4;
  localparam int unsigned DIV_CYCLES = CAND_W / DIV_BPC;
  localparam int unsigned DCNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Candidate value that restarts the sieve, and the limit after reset.
  localparam logic [CAND_W-1:0] RESTART_CAND = CAND_W'(2);
  localparam logic [CAND_W-1:0] LIMIT_RESET  = '1;

  typedef enum logic [3:0] {
    ST_CLEAR,   // sweep the composite flags to zero
    ST_IDLE,    // wait for a candidate
    ST_LOOK,    // classify the candidate, flag read in flight
    ST_FLAG,    // flag read back: decide prime, append to list
    ST_EMIT,    // move the result into the output register
    ST_RDP,     // read the next listed prime
    ST_MUL,     // candidate times prime
    ST_CMP,     // product against limit, mark composite
    ST_DIV      // candidate modulo prime
  } lps_state_t;

endpackage

FILE: sv/lps_if.sv
// Channel interfaces of the linear prime sieve: candidate input, result output
// and the limit write port. Depends on lps_pkg.
interface lps_in_if import lps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CAND_W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface lps_out_if import lps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_prime;
  logic [COUNT_W-1:0] prime_index;
  logic               out_of_range;

  modport source (output valid, output is_prime, output prime_index,
                  output out_of_range, input ready);
  modport sink   (input valid, input is_prime, input prime_index,
                  input out_of_range, output ready);
endinterface

interface lps_cfg_if import lps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CAND_W-1:0] sieve_limit;

  modport source (output valid, output sieve_limit, input ready);
  modport sink   (input valid, input sieve_limit, output ready);
endinterface

FILE: sv/lps_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the composite flags and the prime list. No dependencies.
module lps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/linear_prime_sieve_top.sv
// Top level of the linear prime sieve: sequencer, shared remainder unit and
// output register. Depends on lps_pkg, the interfaces in lps_if and lps_ram.
//
// Channel  Dir  Payload                                  Transfer when
// -------  ---  ---------------------------------------  -------------------
// in_ch    in   candidate[15:0]                          valid && ready
// out_ch   out  is_prime, prime_index[12:0], out_of_range valid && ready
// cfg_ch   in   sieve_limit[15:0]                        valid && ready
//
// A taken candidate passes flag read, prime decision and result load into the
// output register; an out-of-range or small candidate skips the prime decision.
// Each listed prime that the walk marks passes list read, multiply, limit
// compare with flag write and the remainder steps. The walk ends at the list
// read once the list runs out, at the compare of a prime whose product passes
// the limit, or after the remainder of the first prime dividing the candidate.
// The remainder unit, retiring four quotient bits per cycle, sets the cost of
// each walked prime. After reset, and on every transfer of candidate 2, the
// composite flags are swept to zero one entry per cycle over all MAX_VALUE
// (65536) entries, taking no input. A full output register holds the sequencer
// only where the next result loads; the walk itself never waits on the output.
module linear_prime_sieve_top
  import lps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  lps_in_if.sink   in_ch,
  lps_out_if.source out_ch,
  lps_cfg_if.sink  cfg_ch
);

  // Sequencer and control registers.
  lps_state_t          state_r, state_nxt;
  logic [VAL_W-1:0]    clr_r, clr_nxt;        // clear sweep address
  logic                resume_r, resume_nxt;  // clear pass was started by a restart
  logic [COUNT_W-1:0]  count_r, count_nxt;    // number of listed primes
  logic [CAND_W-1:0]   limit_r, limit_nxt;    // sieve_limit register
  logic                out_valid_r, out_valid_nxt;

  // Per-item working registers.
  logic [CAND_W-1:0]   cand_r, cand_nxt;
  logic [CAND_W-1:0]   lim_r, lim_nxt;        // effective limit of this item
  logic [COUNT_W-1:0]  j_r, j_nxt;            // walk position in the list
  logic [CAND_W-1:0]   p_r, p_nxt;
  logic [2*CAND_W-1:0] prod_r, prod_nxt;
  logic [CAND_W:0]     rem_r, rem_nxt;
  logic [CAND_W-1:0]   dvd_r, dvd_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic                walk_r, walk_nxt;

  // Result staged by the sequencer, and the output register.
  logic                res_prime_r, res_prime_nxt;
  logic [COUNT_W-1:0]  res_index_r, res_index_nxt;
  logic                res_oor_r, res_oor_nxt;
  logic                out_prime_r, out_prime_nxt;
  logic [COUNT_W-1:0]  out_index_r, out_index_nxt;
  logic                out_oor_r, out_oor_nxt;

  // Memory ports.
  logic                flag_we;
  logic [VAL_W-1:0]    flag_waddr;
  logic                flag_wdata;
  logic                flag_rdata;
  logic                list_we;
  logic [CAND_W-1:0]   list_rdata;

  // The remainder unit: DIV_BPC restoring steps per cycle.
  logic [CAND_W:0]     div_rem;
  logic [CAND_W-1:0]   div_dvd;

  // Limit seen at the input: clipped to the top of the flag store.
  logic [CAND_W-1:0]   eff_limit;

  assign eff_limit = (32'(limit_r) > VALUE_TOP) ? CAND_W'(VALUE_TOP) : limit_r;

  lps_ram #(
    .WIDTH (1),
    .DEPTH (MAX_VALUE)
  ) u_flags (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .raddr (VAL_W'(cand_r)),
    .rdata (flag_rdata)
  );

  lps_ram #(
    .WIDTH (CAND_W),
    .DEPTH (MAX_PRIMES)
  ) u_list (
    .clk   (clk),
    .we    (list_we),
    .waddr (PRIME_AW'(count_r)),
    .wdata (cand_r),
    .raddr (PRIME_AW'(j_r)),
    .rdata (list_rdata)
  );

  always_comb begin
    logic [CAND_W:0]   r;
    logic [CAND_W-1:0] d;
    r = rem_r;
    d = dvd_r;
    for (int k = 0; k < DIV_BPC; k++) begin
      r = {r[CAND_W-1:0], d[CAND_W-1]};
      d = {d[CAND_W-2:0], 1'b0};
      if (r >= {1'b0, p_r}) begin
        r = r - {1'b0, p_r};
      end
    end
    div_rem = r;
    div_dvd = d;
  end

  // Ports.
  assign in_ch.ready         = (state_r == ST_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.is_prime     = out_prime_r;
  assign out_ch.prime_index  = out_index_r;
  assign out_ch.out_of_range = out_oor_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    resume_nxt    = resume_r;
    count_nxt     = count_r;
    limit_nxt     = limit_r;
    out_valid_nxt = out_valid_r;
    cand_nxt      = cand_r;
    lim_nxt       = lim_r;
    j_nxt         = j_r;
    p_nxt         = p_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    dcnt_nxt      = dcnt_r;
    walk_nxt      = walk_r;
    res_prime_nxt = res_prime_r;
    res_index_nxt = res_index_r;
    res_oor_nxt   = res_oor_r;
    out_prime_nxt = out_prime_r;
    out_index_nxt = out_index_r;
    out_oor_nxt   = out_oor_r;
    flag_we       = 1'b0;
    flag_waddr    = clr_r;
    flag_wdata    = 1'b0;
    list_we       = 1'b0;

    if (cfg_ch.valid) begin
      limit_nxt = cfg_ch.sieve_limit;
    end

    // A taken result empties the output register unless a new one loads.
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        flag_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == VAL_W'(VALUE_TOP)) begin
          state_nxt = resume_r ? ST_LOOK : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_ch.valid) begin
          cand_nxt = in_ch.candidate;
          lim_nxt  = eff_limit;
          if (in_ch.candidate == RESTART_CAND) begin
            // Restart: empty the list and sweep the flags first.
            count_nxt  = '0;
            clr_nxt    = '0;
            resume_nxt = 1'b1;
            state_nxt  = ST_CLEAR;
          end else begin
            state_nxt = ST_LOOK;
          end
        end
      end

      ST_LOOK: begin
        res_prime_nxt = 1'b0;
        res_index_nxt = '0;
        res_oor_nxt   = 1'b0;
        walk_nxt      = 1'b0;
        if (cand_r > lim_r) begin
          res_oor_nxt = 1'b1;
          state_nxt   = ST_EMIT;
        end else if (cand_r < RESTART_CAND) begin
          // Zero and one are neither prime nor walked.
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_FLAG;
        end
      end

      ST_FLAG: begin
        res_prime_nxt = !flag_rdata;
        walk_nxt      = 1'b1;
        j_nxt         = '0;
        if (!flag_rdata && (count_r < COUNT_W'(LIST_CAP))) begin
          list_we       = 1'b1;
          count_nxt     = count_r + 1'b1;
          res_index_nxt = count_r + 1'b1;
        end
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = res_prime_r;
          out_index_nxt = res_index_r;
          out_oor_nxt   = res_oor_r;
          state_nxt     = walk_r ? ST_RDP : ST_IDLE;
        end
      end

      ST_RDP: begin
        state_nxt = (j_r == count_r) ? ST_IDLE : ST_MUL;
      end

      ST_MUL: begin
        p_nxt    = list_rdata;
        prod_nxt = cand_r * list_rdata;
        state_nxt = (list_rdata == '0) ? ST_IDLE : ST_CMP;
      end

      ST_CMP: begin
        if (prod_r > {{CAND_W{1'b0}}, lim_r}) begin
          state_nxt = ST_IDLE;
        end else begin
          flag_we    = 1'b1;
          flag_waddr = VAL_W'(prod_r);
          flag_wdata = 1'b1;
          rem_nxt    = '0;
          dvd_nxt    = cand_r;
          dcnt_nxt   = '0;
          state_nxt  = ST_DIV;
        end
      end

      ST_DIV: begin
        rem_nxt  = div_rem;
        dvd_nxt  = div_dvd;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(DIV_CYCLES - 1)) begin
          // The first prime that divides the candidate ends the walk.
          if (div_rem == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_RDP;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      resume_r    <= 1'b0;
      count_r     <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      resume_r    <= resume_nxt;
      count_r     <= count_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    lim_r       <= lim_nxt;
    j_r         <= j_nxt;
    p_r         <= p_nxt;
    prod_r      <= prod_nxt;
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
    dcnt_r      <= dcnt_nxt;
    walk_r      <= walk_nxt;
    res_prime_r <= res_prime_nxt;
    res_index_r <= res_index_nxt;
    res_oor_r   <= res_oor_nxt;
    out_prime_r <= out_prime_nxt;
    out_index_r <= out_index_nxt;
    out_oor_r   <= out_oor_nxt;
  end

`ifndef SYNTHESIS
  // A restart empties the list and starts the flag sweep on the next cycle.
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && (in_ch.candidate == RESTART_CAND)
    |=> (state_r == ST_CLEAR) && (count_r == '0) && (clr_r == '0))
    else $error("restart did not start the clear sweep");

  // The prime count never grows past the list capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(LIST_CAP))
    else $error("prime count above list capacity");

  // An out-of-range result carries neither a prime nor a list position.
  a_oor_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_oor_r |-> !out_prime_r && (out_index_r == '0))
    else $error("out-of-range result reports a prime");

  // A list position is only given for a prime.
  a_index_prime: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_index_r != '0) |-> out_prime_r)
    else $error("list position given for a composite");
`endif

endmodule
